// ===== design/tgca_pkg.sv =====
// Shared types, glyph constants and lookup functions for the Thai glyph cluster adjuster.
// No dependencies; every other file in the design uses this package.
`timescale 1ns / 1ps
`default_nettype none

package tgca_pkg;

  localparam int FIFO_DEPTH_DEF = 4;
  localparam int JOB_SLOTS = 5;

  localparam logic [7:0] SARA_AM         = 8'hD3;
  localparam logic [7:0] SARA_AA         = 8'hD2;
  localparam logic [7:0] NIKHAHIT        = 8'hED;
  localparam logic [7:0] TOP_DROP        = 8'd96;
  localparam logic [7:0] LOW_RAISE       = 8'd36;
  localparam logic [7:0] CH_PO_PLA       = 8'hBB;
  localparam logic [7:0] CH_FO_FA        = 8'hBD;
  localparam logic [7:0] CH_FO_FAN       = 8'hBF;
  localparam logic [7:0] CH_THO_THAN     = 8'hB0;
  localparam logic [7:0] GL_THO_THAN_NT  = 8'h9F;
  localparam logic [7:0] CH_YO_YING      = 8'hAD;
  localparam logic [7:0] GL_YO_YING_NT   = 8'h90;
  localparam logic [7:0] CH_DO_CHADA     = 8'hAE;
  localparam logic [7:0] CH_TO_PATAK     = 8'hAF;

  typedef enum logic [1:0] {
    LVL_BASE,
    LVL_LOW,
    LVL_UPPER,
    LVL_TOP
  } level_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       line_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] base;
    logic [7:0] low;
    logic [7:0] upper;
    logic [7:0] top;
  } cluster_t;

  // Slots are base, low, upper, top of the closed cluster, then a base opened and flushed.
  typedef struct packed {
    logic [JOB_SLOTS-1:0][7:0] glyph;
    logic [JOB_SLOTS-1:0]      present;
    logic                      line_end;
  } job_t;

  function automatic level_t level_of(input logic [7:0] c);
    level_t lvl;
    unique case (c)
      8'hD1, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hE7, 8'hED: lvl = LVL_UPPER;
      8'hD8, 8'hD9, 8'hDA, 8'hFC, 8'hFD:               lvl = LVL_LOW;
      8'hE8, 8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hEE:        lvl = LVL_TOP;
      default:                                         lvl = LVL_BASE;
    endcase
    return lvl;
  endfunction

  function automatic logic [7:0] shift_left(input logic [7:0] c);
    logic [7:0] g;
    unique case (c)
      8'h88:   g = 8'h83;
      8'h89:   g = 8'h84;
      8'h8A:   g = 8'h85;
      8'h8B:   g = 8'h86;
      8'h8C:   g = 8'h87;
      8'hED:   g = 8'h8F;
      8'hE8:   g = 8'h98;
      8'hE9:   g = 8'h99;
      8'hEA:   g = 8'h9A;
      8'hEB:   g = 8'h9B;
      8'hEC:   g = 8'h9C;
      8'hD4:   g = 8'h94;
      8'hD5:   g = 8'h95;
      8'hD6:   g = 8'h96;
      8'hD7:   g = 8'h97;
      8'hD1:   g = 8'h92;
      8'hE7:   g = 8'h93;
      default: g = c;
    endcase
    return g;
  endfunction

  function automatic cluster_t adjust(input cluster_t cl);
    cluster_t r;
    r = cl;
    if (r.top != 8'h00 && r.upper == 8'h00) begin
      r.upper = r.top - TOP_DROP;
      r.top   = 8'h00;
    end
    if (r.base == CH_PO_PLA || r.base == CH_FO_FA || r.base == CH_FO_FAN) begin
      if (r.upper != 8'h00) r.upper = shift_left(r.upper);
      if (r.top != 8'h00) r.top = shift_left(r.top);
    end
    if (r.base == CH_THO_THAN && r.low != 8'h00) r.base = GL_THO_THAN_NT;
    if (r.base == CH_YO_YING && r.low != 8'h00) r.base = GL_YO_YING_NT;
    if ((r.base == CH_DO_CHADA || r.base == CH_TO_PATAK) && r.low != 8'h00) begin
      r.low = r.low + LOW_RAISE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/tgca_front.sv =====
// Front end: classifies each input byte, keeps the pending cluster and builds emit jobs.
// Depends on tgca_pkg for types, level and glyph lookup functions.
`timescale 1ns / 1ps
`default_nettype none

module tgca_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  tgca_pkg::in_item_t     in_data,
  output logic                   in_ready,
  input  wire logic              fifo_full,
  output logic                   push,
  output tgca_pkg::job_t         job
);

  logic               valid_r, valid_nxt;
  tgca_pkg::cluster_t pend_r, pend_nxt;
  tgca_pkg::cluster_t closing;
  tgca_pkg::cluster_t adj;
  tgca_pkg::level_t   lvl;
  logic               is_base;
  logic               emit_a;
  logic               accept;
  logic [7:0]         new_base;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    lvl      = tgca_pkg::level_of(in_data.in_byte);
    is_base  = (lvl == tgca_pkg::LVL_BASE);
    new_base = (in_data.in_byte == tgca_pkg::SARA_AM) ? tgca_pkg::SARA_AA : in_data.in_byte;

    closing = pend_r;
    unique case (lvl)
      tgca_pkg::LVL_LOW:   closing.low   = in_data.in_byte;
      tgca_pkg::LVL_UPPER: closing.upper = in_data.in_byte;
      tgca_pkg::LVL_TOP:   closing.top   = in_data.in_byte;
      tgca_pkg::LVL_BASE: begin
        if (in_data.in_byte == tgca_pkg::SARA_AM) closing.upper = tgca_pkg::NIKHAHIT;
      end
    endcase
    adj    = tgca_pkg::adjust(closing);
    emit_a = valid_r && (is_base || in_data.line_end);

    job.glyph[0]   = adj.base;
    job.glyph[1]   = adj.low;
    job.glyph[2]   = adj.upper;
    job.glyph[3]   = adj.top;
    job.glyph[4]   = new_base;
    job.present[0] = emit_a;
    job.present[1] = emit_a && (adj.low != 8'h00);
    job.present[2] = emit_a && (adj.upper != 8'h00);
    job.present[3] = emit_a && (adj.top != 8'h00);
    job.present[4] = is_base && in_data.line_end;
    job.line_end   = in_data.line_end;
    push           = accept && (|job.present);

    valid_nxt = valid_r;
    pend_nxt  = pend_r;
    if (accept) begin
      if (in_data.line_end) begin
        valid_nxt = 1'b0;
      end else if (is_base) begin
        valid_nxt = 1'b1;
        pend_nxt  = '{base: new_base, low: 8'h00, upper: 8'h00, top: 8'h00};
      end else begin
        pend_nxt = closing;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

// ===== design/tgca_fifo.sv =====
// Short job queue between the front end and the byte serializer.
// Depends on tgca_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module tgca_fifo #(
  parameter int DEPTH = tgca_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  tgca_pkg::job_t push_data,
  output logic           full,
  input  wire logic      pop,
  output logic           rd_valid,
  output tgca_pkg::job_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tgca_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgca_back.sv =====
// Back end: takes one job at a time and sends its present glyphs one byte per transaction.
// Depends on tgca_pkg for the job and result types.
`timescale 1ns / 1ps
`default_nettype none

module tgca_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fifo_valid,
  input  tgca_pkg::job_t    fifo_data,
  output logic              fifo_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output tgca_pkg::out_item_t out_data
);

  localparam int N = tgca_pkg::JOB_SLOTS;

  logic [N-1:0][7:0] glyph_r;
  logic [N-1:0]      present_r, present_nxt;
  logic              line_r;
  logic [N-1:0]      pick;
  logic [N-1:0]      rest;
  logic [7:0]        sel;
  logic              last;
  logic              take;

  always_comb begin
    pick = present_r & (~present_r + 1'b1);
    rest = present_r & ~pick;
    last = (rest == '0);
    sel  = 8'h00;
    for (int i = 0; i < N; i++) begin
      sel = sel | (glyph_r[i] & {8{pick[i]}});
    end
    out_valid          = |present_r;
    out_data.out_byte  = sel;
    out_data.run_last  = last;
    out_data.line_last = last && line_r;
    take     = !out_valid || (out_ready && last);
    fifo_pop = take && fifo_valid;

    present_nxt = present_r;
    if (take) begin
      present_nxt = fifo_valid ? fifo_data.present : '0;
    end else if (out_ready) begin
      present_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      present_r <= present_nxt;
    end
    if (fifo_pop) begin
      glyph_r <= fifo_data.glyph;
      line_r  <= fifo_data.line_end;
    end
  end

endmodule

`default_nettype wire

// ===== design/thai_glyph_cluster_adjuster_unit.sv =====
// Thai glyph cluster adjuster, top level: front end, job queue and byte serializer.
// Accepts one input byte per cycle while the queue has room; sends one output byte per cycle while out_ready is high.
// The first byte of a closed cluster is offered once its job is written to the queue and then loaded by the serializer.
// Each glyph of a cluster goes out as its own output byte; FIFO_DEPTH jobs absorb bursts between the sides.
// Synchronous active-low reset empties the queue and drops any pending cluster.
`timescale 1ns / 1ps
`default_nettype none

module thai_glyph_cluster_adjuster_unit #(
  parameter int FIFO_DEPTH = tgca_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  tgca_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tgca_pkg::out_item_t out_data
);

  tgca_pkg::job_t push_job;
  tgca_pkg::job_t head_job;
  logic           push;
  logic           fifo_full;
  logic           fifo_valid;
  logic           fifo_pop;

  tgca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .fifo_full (fifo_full),
    .push      (push),
    .job       (push_job)
  );

  tgca_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .rd_valid  (fifo_valid),
    .rd_data   (head_job)
  );

  tgca_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_valid (fifo_valid),
    .fifo_data  (head_job),
    .fifo_pop   (fifo_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_line_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.line_last |-> out_data.run_last)
    else $error("line_last without run_last");

  a_drain_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.run_last && !fifo_valid |=> !out_valid)
    else $error("output still valid after last job drained");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> fifo_valid)
    else $error("queue full while empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fifo_full)
    else $error("job pushed into full queue");

endmodule

`default_nettype wire

// ===== verif/thai_glyph_cluster_adjuster_unit_tb.sv =====
// Self-checking testbench for the Thai glyph cluster adjuster top level.
// Depends on tgca_pkg and thai_glyph_cluster_adjuster_unit; a scoreboard class predicts
// the adjusted glyph stream of each line and checks every output transaction in order.
`timescale 1ns / 1ps

module thai_glyph_cluster_adjuster_unit_tb;

  localparam int TEXT_ITEMS = 480;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  class glyph_scoreboard;
    bit                  held;
    logic [7:0]          held_base;
    logic [7:0]          held_low;
    logic [7:0]          held_upper;
    logic [7:0]          held_top;
    tgca_pkg::out_item_t step_glyphs[$];
    tgca_pkg::out_item_t expected_glyphs[$];
    int                  error_count;

    function new();
      held = 1'b0;
      held_base = 8'h00;
      held_low = 8'h00;
      held_upper = 8'h00;
      held_top = 8'h00;
      error_count = 0;
    endfunction

    function tgca_pkg::level_t glyph_level(logic [7:0] c);
      tgca_pkg::level_t lvl;
      case (c)
        8'hD8, 8'hD9, 8'hDA, 8'hFC, 8'hFD: lvl = tgca_pkg::LVL_LOW;
        8'hD1, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hE7, 8'hED: lvl = tgca_pkg::LVL_UPPER;
        8'hE8, 8'hE9, 8'hEA, 8'hEB, 8'hEC, 8'hEE: lvl = tgca_pkg::LVL_TOP;
        default: lvl = tgca_pkg::LVL_BASE;
      endcase
      return lvl;
    endfunction

    function logic [7:0] tall_glyph(logic [7:0] c);
      logic [7:0] g;
      case (c)
        8'h88: g = 8'h83;
        8'h89: g = 8'h84;
        8'h8A: g = 8'h85;
        8'h8B: g = 8'h86;
        8'h8C: g = 8'h87;
        8'hED: g = 8'h8F;
        8'hE8: g = 8'h98;
        8'hE9: g = 8'h99;
        8'hEA: g = 8'h9A;
        8'hEB: g = 8'h9B;
        8'hEC: g = 8'h9C;
        8'hD4: g = 8'h94;
        8'hD5: g = 8'h95;
        8'hD6: g = 8'h96;
        8'hD7: g = 8'h97;
        8'hD1: g = 8'h92;
        8'hE7: g = 8'h93;
        default: g = c;
      endcase
      return g;
    endfunction

    function void put_glyph(logic [7:0] v);
      tgca_pkg::out_item_t g;
      g = '0;
      g.out_byte = v;
      step_glyphs.push_back(g);
    endfunction

    function void close_cluster();
      logic [7:0] b;
      logic [7:0] lo;
      logic [7:0] up;
      logic [7:0] tp;
      if (!held) return;
      b = held_base;
      lo = held_low;
      up = held_upper;
      tp = held_top;
      if (tp != 8'h00 && up == 8'h00) begin
        up = tp - tgca_pkg::TOP_DROP;
        tp = 8'h00;
      end
      if (b == tgca_pkg::CH_PO_PLA || b == tgca_pkg::CH_FO_FA || b == tgca_pkg::CH_FO_FAN) begin
        if (up != 8'h00) up = tall_glyph(up);
        if (tp != 8'h00) tp = tall_glyph(tp);
      end
      if (b == tgca_pkg::CH_THO_THAN && lo != 8'h00) b = tgca_pkg::GL_THO_THAN_NT;
      if (b == tgca_pkg::CH_YO_YING && lo != 8'h00) b = tgca_pkg::GL_YO_YING_NT;
      if ((b == tgca_pkg::CH_DO_CHADA || b == tgca_pkg::CH_TO_PATAK) && lo != 8'h00)
        lo = lo + tgca_pkg::LOW_RAISE;
      put_glyph(b);
      if (lo != 8'h00) put_glyph(lo);
      if (up != 8'h00) put_glyph(up);
      if (tp != 8'h00) put_glyph(tp);
      held = 1'b0;
    endfunction

    function void note_input(tgca_pkg::in_item_t it);
      logic [7:0] c;
      c = it.in_byte;
      step_glyphs.delete();
      case (glyph_level(c))
        tgca_pkg::LVL_LOW: if (held) held_low = c;
        tgca_pkg::LVL_UPPER: if (held) held_upper = c;
        tgca_pkg::LVL_TOP: if (held) held_top = c;
        default: begin
          if (c == tgca_pkg::SARA_AM) begin
            if (held) held_upper = tgca_pkg::NIKHAHIT;
            c = tgca_pkg::SARA_AA;
          end
          close_cluster();
          held = 1'b1;
          held_base = c;
          held_low = 8'h00;
          held_upper = 8'h00;
          held_top = 8'h00;
        end
      endcase
      if (it.line_end) begin
        close_cluster();
        held_base = 8'h00;
        held_low = 8'h00;
        held_upper = 8'h00;
        held_top = 8'h00;
      end
      if (step_glyphs.size() > 0) begin
        step_glyphs[step_glyphs.size()-1].run_last = 1'b1;
        step_glyphs[step_glyphs.size()-1].line_last = it.line_end;
      end
      foreach (step_glyphs[i]) expected_glyphs.push_back(step_glyphs[i]);
    endfunction

    function void check_result(tgca_pkg::out_item_t got);
      tgca_pkg::out_item_t want;
      if (expected_glyphs.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected output transaction: byte=%h run_last=%b line_last=%b",
                   got.out_byte, got.run_last, got.line_last);
      end else begin
        want = expected_glyphs.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.line_last !== want.line_last) begin
          error_count++;
          if (error_count <= 10)
            $display("Mismatch (byte/run_last/line_last): expected %h/%b/%b, got %h/%b/%b",
                     want.out_byte, want.run_last, want.line_last,
                     got.out_byte, got.run_last, got.line_last);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  tgca_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  tgca_pkg::out_item_t out_data;

  glyph_scoreboard    sb;
  tgca_pkg::in_item_t text_q[$];
  int                 quiet_cycles = 0;
  int                 stall_tick = 0;
  int                 stall_style = 0;

  thai_glyph_cluster_adjuster_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    stall_tick <= stall_tick + 1;
    if (stall_tick % 128 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_tick % 8 < 5);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic tgca_pkg::in_item_t text_char(logic [7:0] c, logic le);
    tgca_pkg::in_item_t it;
    it.in_byte = c;
    it.line_end = le;
    return it;
  endfunction

  function automatic logic [7:0] random_mark();
    logic [7:0] m;
    case ($urandom_range(0, 17))
      0: m = 8'hD8;
      1: m = 8'hD9;
      2: m = 8'hDA;
      3: m = 8'hFC;
      4: m = 8'hFD;
      5: m = 8'hD1;
      6: m = 8'hD4;
      7: m = 8'hD5;
      8: m = 8'hD6;
      9: m = 8'hD7;
      10: m = 8'hE7;
      11: m = tgca_pkg::NIKHAHIT;
      12: m = 8'hE8;
      13: m = 8'hE9;
      14: m = 8'hEA;
      15: m = 8'hEB;
      16: m = 8'hEC;
      default: m = 8'hEE;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] random_base();
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0: b = tgca_pkg::CH_PO_PLA;
      1: b = tgca_pkg::CH_FO_FA;
      2: b = tgca_pkg::CH_FO_FAN;
      3: b = tgca_pkg::CH_THO_THAN;
      4: b = tgca_pkg::CH_YO_YING;
      5: b = tgca_pkg::CH_DO_CHADA;
      6: b = tgca_pkg::CH_TO_PATAK;
      7: b = tgca_pkg::SARA_AM;
      default: b = 8'($urandom_range(0, 8'hD0));
    endcase
    return b;
  endfunction

  task automatic build_text();
    int kept;
    int roll;
    int marks;
    bit ends_line;
    kept = 0;
    while (kept < TEXT_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll < 2) begin
        text_q.push_back(text_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0));
        kept++;
      end else if (roll < 3) begin
        text_q.push_back(text_char(random_mark(), 1'($urandom_range(0, 1))));
        kept++;
      end else begin
        marks = $urandom_range(0, 3);
        ends_line = ($urandom_range(0, 5) == 0);
        text_q.push_back(text_char(random_base(), ends_line && marks == 0));
        for (int i = 0; i < marks; i++)
          text_q.push_back(text_char(random_mark(), ends_line && i == marks - 1));
        kept += marks + 1;
      end
    end
  endtask

  task automatic send_char(tgca_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic send_text();
    int burst;
    int gap;
    while (text_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && text_q.size() > 0; i++) send_char(text_q.pop_front());
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        in_data <= tgca_pkg::in_item_t'(9'($urandom_range(0, 511)));
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Marks with no cluster open are dropped.
    text_q.push_back(text_char(8'hE8, 1'b0));
    text_q.push_back(text_char(8'hD8, 1'b0));
    text_q.push_back(text_char(8'h00, 1'b0));
    // Tall consonant with upper and top marks.
    text_q.push_back(text_char(tgca_pkg::CH_PO_PLA, 1'b0));
    text_q.push_back(text_char(8'hD4, 1'b0));
    text_q.push_back(text_char(8'hE8, 1'b0));
    // Tail-less substitutions under a low vowel.
    text_q.push_back(text_char(tgca_pkg::CH_THO_THAN, 1'b0));
    text_q.push_back(text_char(8'hD8, 1'b0));
    text_q.push_back(text_char(tgca_pkg::CH_YO_YING, 1'b0));
    text_q.push_back(text_char(8'hD9, 1'b0));
    // Raised low vowels, including the wrap past 0xFF.
    text_q.push_back(text_char(tgca_pkg::CH_DO_CHADA, 1'b0));
    text_q.push_back(text_char(8'hFC, 1'b0));
    text_q.push_back(text_char(tgca_pkg::CH_TO_PATAK, 1'b0));
    text_q.push_back(text_char(8'hFD, 1'b0));
    // Sara Am on a pending cluster, then a top mark that drops to upper.
    text_q.push_back(text_char(tgca_pkg::SARA_AM, 1'b0));
    text_q.push_back(text_char(8'hE9, 1'b0));
    text_q.push_back(text_char(tgca_pkg::CH_FO_FAN, 1'b0));
    text_q.push_back(text_char(8'hEE, 1'b0));
    text_q.push_back(text_char(8'hFF, 1'b1));
    // Sara Am with nothing pending, then a full cluster flushed with a new base.
    text_q.push_back(text_char(tgca_pkg::SARA_AM, 1'b0));
    text_q.push_back(text_char(8'hDA, 1'b0));
    text_q.push_back(text_char(8'hD1, 1'b0));
    text_q.push_back(text_char(8'hEC, 1'b0));
    text_q.push_back(text_char(8'h41, 1'b1));
    // A line end that produces nothing.
    text_q.push_back(text_char(8'hE7, 1'b1));

    build_text();
    send_text();

    while (sb.expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
